@@ src/radial_light_stamp_map_defines.svh @@
// Assertion macros for the radial light stamp map.
`ifndef RADIAL_LIGHT_STAMP_MAP_DEFINES_SVH
`define RADIAL_LIGHT_STAMP_MAP_DEFINES_SVH

// same-cycle implication
`define RLSM_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLSM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rlsm_pkg.sv @@
// Shared types and constants of the radial light stamp map.
`default_nettype none
package rlsm_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned RAD_W  = 5;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned DIM_W  = POS_W + 1;
  localparam int unsigned NUM_W  = VAL_W + RAD_W;
  localparam int unsigned SQ_W   = 2 * RAD_W + 1;
  localparam int unsigned ROOT_W = RAD_W;
  localparam int unsigned AFULL_W = POS_W + DIM_W + 1;
  localparam int unsigned TBL_N  = 2 ** RAD_W;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef struct packed {
    logic capture;
    logic mem_wr_pos;
    logic mem_rd_pos;
    logic tbl_mul;
    logic div_step;
    logic tbl_wr;
    logic cell_eval;
    logic cell_rd;
    logic sqrt_step;
    logic cell_wr;
    logic cell_next;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic is_load;
    logic is_read;
    logic r_zero;
    logic div_last;
    logic tbl_last;
    logic in_disc;
    logic sqrt_last;
    logic cell_last;
  } sts_t;

endpackage
`default_nettype wire

@@ src/rlsm_ctrl.sv @@
// Sequencing state machine of the radial light stamp map.
`default_nettype none
module rlsm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  rlsm_pkg::sts_t     sts_i,
  output rlsm_pkg::cmd_t     cmd_o,
  output logic               busy,
  output logic               done_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TBL_MUL,
    ST_DIV,
    ST_TBL_WR,
    ST_CELL_EVAL,
    ST_CELL_RD,
    ST_SQRT,
    ST_CELL_WR,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start;
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.reject) begin
          state_d = ST_RESULT;
        end else if (sts_i.is_load) begin
          cmd_o.mem_wr_pos = 1'b1;
          state_d = ST_RESULT;
        end else if (sts_i.is_read) begin
          cmd_o.mem_rd_pos = 1'b1;
          state_d = ST_RESULT;
        end else if (sts_i.r_zero) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_TBL_MUL;
        end
      end
      ST_TBL_MUL: begin
        cmd_o.tbl_mul = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_TBL_WR;
      end
      ST_TBL_WR: begin
        cmd_o.tbl_wr = 1'b1;
        state_d = sts_i.tbl_last ? ST_CELL_EVAL : ST_TBL_MUL;
      end
      ST_CELL_EVAL: begin
        cmd_o.cell_eval = 1'b1;
        state_d = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        if (sts_i.in_disc) begin
          cmd_o.cell_rd = 1'b1;
          state_d = ST_SQRT;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d = sts_i.cell_last ? ST_RESULT : ST_CELL_EVAL;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        cmd_o.cell_wr   = 1'b1;
        cmd_o.cell_next = 1'b1;
        state_d = sts_i.cell_last ? ST_RESULT : ST_CELL_EVAL;
      end
      ST_RESULT: begin
        cmd_o.result = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_RESULT);
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ src/rlsm_dp.sv @@
// Datapath of the radial light stamp map: map memory, gain table, divider, square root.
`default_nettype none
module rlsm_dp #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 31
) (
  input  wire logic                        clk_i,
  input  rlsm_pkg::cmd_t                   cmd_i,
  output rlsm_pkg::sts_t                   sts_o,
  input  wire logic [rlsm_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [rlsm_pkg::POS_W-1:0]  pos_x_i,
  input  wire logic [rlsm_pkg::POS_W-1:0]  pos_y_i,
  input  wire logic [rlsm_pkg::RAD_W-1:0]  radius_i,
  input  wire logic [rlsm_pkg::VAL_W-1:0]  peak_light_i,
  input  wire logic [rlsm_pkg::VAL_W-1:0]  load_value_i,
  input  wire logic [rlsm_pkg::DIM_W-1:0]  map_width_i,
  input  wire logic [rlsm_pkg::DIM_W-1:0]  map_height_i,
  output logic      [rlsm_pkg::VAL_W-1:0]  cell_value_o,
  output logic                             status_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DMAX  = (2 ** rlsm_pkg::DIM_W) - 1;
  localparam int unsigned RMAX  = (2 ** rlsm_pkg::RAD_W) - 1;
  localparam int unsigned WCAP  = (MAX_WIDTH > DMAX) ? DMAX : MAX_WIDTH;
  localparam int unsigned HCAP  = (MAX_HEIGHT > DMAX) ? DMAX : MAX_HEIGHT;
  localparam int unsigned RCAP  = (MAX_RADIUS > RMAX) ? RMAX : MAX_RADIUS;
  localparam int unsigned CNT_W = $clog2(rlsm_pkg::NUM_W);
  localparam int unsigned BI_W  = $clog2(rlsm_pkg::ROOT_W);

  localparam int unsigned PW = rlsm_pkg::POS_W;
  localparam int unsigned RW = rlsm_pkg::RAD_W;
  localparam int unsigned VW = rlsm_pkg::VAL_W;
  localparam int unsigned DW = rlsm_pkg::DIM_W;
  localparam int unsigned NW = rlsm_pkg::NUM_W;
  localparam int unsigned SW = rlsm_pkg::SQ_W;
  localparam int unsigned TW = rlsm_pkg::ROOT_W;
  localparam int unsigned FW = rlsm_pkg::AFULL_W;

  // operation registers
  rlsm_pkg::op_e  op_q;
  logic [PW-1:0]  x_q, y_q, cx_q, cy_q;
  logic [RW-1:0]  r_q, s_q;
  logic [2*RW-1:0] rr_q;
  logic [VW-1:0]  peak_q, ld_q;

  // table fill and divider
  logic [VW-1:0]    amt_tbl_q [rlsm_pkg::TBL_N];
  logic [NW-1:0]    quo_q;
  logic [RW-1:0]    rem_q;
  logic [CNT_W-1:0] cnt_q;

  // cell pass
  logic [AW-1:0]  addr_q;
  logic [SW-1:0]  d2_q;
  logic [TW-1:0]  root_q;
  logic [BI_W-1:0] bidx_q;

  // memory
  logic [VW-1:0]  light_store_q [DEPTH];
  logic [VW-1:0]  rdata_q;

  logic [VW-1:0]  cell_q;
  logic           status_q;

  // bounds checks
  logic [DW-1:0] w_eff, h_eff, x_ext, y_ext, r_ext;
  logic          in_map, disc_ok, is_disc, reject;

  assign w_eff = (map_width_i  > DW'(WCAP)) ? DW'(WCAP) : map_width_i;
  assign h_eff = (map_height_i > DW'(HCAP)) ? DW'(HCAP) : map_height_i;
  assign x_ext = DW'(x_q);
  assign y_ext = DW'(y_q);
  assign r_ext = DW'(r_q);

  assign in_map  = (x_ext < w_eff) && (y_ext < h_eff);
  assign disc_ok = (r_q <= RW'(RCAP)) && (x_ext >= r_ext) && (y_ext >= r_ext) &&
                   ((x_ext + r_ext) < w_eff) && ((y_ext + r_ext) < h_eff);
  assign is_disc = (op_q == rlsm_pkg::OP_ADD) || (op_q == rlsm_pkg::OP_REMOVE);
  assign reject  = is_disc ? !disc_ok : !in_map;

  // addresses
  logic [FW-1:0] pos_addr_full, cell_addr_full;
  logic [AW-1:0] pos_addr;

  assign pos_addr_full  = FW'(x_q) + FW'(y_q) * FW'(w_eff);
  assign cell_addr_full = FW'(cx_q) + FW'(cy_q) * FW'(w_eff);
  assign pos_addr       = AW'(pos_addr_full);

  // cell distance
  logic [PW-1:0] dxw, dyw, x_end, y_end;
  logic [RW-1:0] dx, dy;
  logic [SW-1:0] d2;

  assign dxw   = (cx_q >= x_q) ? (cx_q - x_q) : (x_q - cx_q);
  assign dyw   = (cy_q >= y_q) ? (cy_q - y_q) : (y_q - cy_q);
  assign dx    = dxw[RW-1:0];
  assign dy    = dyw[RW-1:0];
  assign d2    = SW'(dx * dx) + SW'(dy * dy);
  assign x_end = x_q + PW'(r_q);
  assign y_end = y_q + PW'(r_q);

  // divider step
  logic [RW:0]   rem_sh;
  logic          div_ge;
  logic [RW-1:0] rem_d;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign div_ge = (rem_sh >= {1'b0, r_q});
  assign rem_d  = div_ge ? RW'(rem_sh - {1'b0, r_q}) : rem_sh[RW-1:0];

  // square root step
  logic [TW-1:0]   trial;
  logic [2*TW-1:0] trial_sq;

  assign trial    = root_q | (TW'(1) << bidx_q);
  assign trial_sq = trial * trial;

  // cell update
  logic [VW-1:0] amt, new_val;
  logic [VW:0]   add_sum;

  assign amt     = amt_tbl_q[root_q];
  assign add_sum = {1'b0, rdata_q} + {1'b0, amt};
  always_comb begin
    if (op_q == rlsm_pkg::OP_ADD) begin
      new_val = add_sum[VW] ? '1 : add_sum[VW-1:0];
    end else begin
      new_val = (rdata_q > amt) ? (rdata_q - amt) : '0;
    end
  end

  // memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata;

  assign mem_we = cmd_i.mem_wr_pos | cmd_i.cell_wr;
  assign mem_re = cmd_i.mem_rd_pos | cmd_i.cell_rd;
  assign waddr  = cmd_i.cell_wr ? addr_q : pos_addr;
  assign wdata  = cmd_i.cell_wr ? new_val : ld_q;
  assign raddr  = cmd_i.cell_rd ? addr_q : pos_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) light_store_q[waddr] <= wdata;
    if (mem_re) rdata_q <= light_store_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= rlsm_pkg::op_e'(opcode_i);
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      r_q    <= radius_i;
      rr_q   <= radius_i * radius_i;
      peak_q <= peak_light_i;
      ld_q   <= load_value_i;
      s_q    <= '0;
      cx_q   <= pos_x_i - PW'(radius_i);
      cy_q   <= pos_y_i - PW'(radius_i);
    end
    if (cmd_i.tbl_mul) begin
      quo_q <= NW'(peak_q * (r_q - s_q));
      rem_q <= '0;
      cnt_q <= CNT_W'(NW - 1);
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[NW-2:0], div_ge};
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.tbl_wr) begin
      amt_tbl_q[s_q] <= quo_q[VW-1:0];
      s_q            <= s_q + 1'b1;
    end
    if (cmd_i.cell_eval) begin
      addr_q <= AW'(cell_addr_full);
      d2_q   <= d2;
    end
    if (cmd_i.cell_rd) begin
      root_q <= '0;
      bidx_q <= BI_W'(TW - 1);
    end
    if (cmd_i.sqrt_step) begin
      if (SW'(trial_sq) <= d2_q) root_q <= trial;
      bidx_q <= bidx_q - 1'b1;
    end
    if (cmd_i.cell_next) begin
      if (cx_q == x_end) begin
        cx_q <= x_q - PW'(r_q);
        cy_q <= cy_q + 1'b1;
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end
    if (cmd_i.result) begin
      cell_q   <= ((op_q == rlsm_pkg::OP_READ) && !reject) ? rdata_q : '0;
      status_q <= reject;
    end
  end

  assign sts_o.reject    = reject;
  assign sts_o.is_load   = (op_q == rlsm_pkg::OP_LOAD);
  assign sts_o.is_read   = (op_q == rlsm_pkg::OP_READ);
  assign sts_o.r_zero    = (r_q == '0);
  assign sts_o.div_last  = (cnt_q == '0);
  assign sts_o.tbl_last  = (s_q == r_q);
  assign sts_o.in_disc   = (d2_q <= SW'(rr_q));
  assign sts_o.sqrt_last = (bidx_q == '0);
  assign sts_o.cell_last = (cx_q == x_end) && (cy_q == y_end);

  assign cell_value_o = cell_q;
  assign status_o     = status_q;

endmodule
`default_nettype wire

@@ src/radial_light_stamp_map.sv @@
// Top level of the radial light stamp map: size registers, controller and datapath.
// Load, read, rejected ops and zero-radius discs: done_o two edges after start, busy low
//   with done_o, so one transfer every 3 cycles; done_o is a strobe and never stalls.
// Disc of radius r: 2 + 15*(r+1) + 8*(cells within r) + 2*(other cells in the box) cycles,
// about 26400 at radius 31; 15 per table entry (13-step divider), 8 per cell (5-step root).
// Reset idles the controller and sets both sizes to 64; map contents stay undefined.
`default_nettype none
`include "radial_light_stamp_map_defines.svh"
module radial_light_stamp_map #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 31
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rlsm_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [rlsm_pkg::POS_W-1:0]  pos_x_i,
  input  wire logic [rlsm_pkg::POS_W-1:0]  pos_y_i,
  input  wire logic [rlsm_pkg::RAD_W-1:0]  radius_i,
  input  wire logic [rlsm_pkg::VAL_W-1:0]  peak_light_i,
  input  wire logic [rlsm_pkg::VAL_W-1:0]  load_value_i,
  output logic                             done_o,
  output logic      [rlsm_pkg::VAL_W-1:0]  cell_value_o,
  output logic                             status_o
);

  localparam int unsigned DW = rlsm_pkg::DIM_W;

  logic [DW-1:0] map_width_q, map_height_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DW'(64);
      map_height_q <= DW'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == rlsm_pkg::REG_MAP_WIDTH)  map_width_q  <= pwdata[DW-1:0];
      if (paddr[2] == rlsm_pkg::REG_MAP_HEIGHT) map_height_q <= pwdata[DW-1:0];
    end
  end

  assign prdata = (paddr[2] == rlsm_pkg::REG_MAP_HEIGHT) ? 32'(map_height_q) :
                                                           32'(map_width_q);

  rlsm_pkg::cmd_t cmd;
  rlsm_pkg::sts_t sts;

  rlsm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  rlsm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .radius_i     (radius_i),
    .peak_light_i (peak_light_i),
    .load_value_i (load_value_i),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .cell_value_o (cell_value_o),
    .status_o     (status_o)
  );

  `RLSM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted transfer did not raise busy")
  `RLSM_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy, "result strobe while busy")
  `RLSM_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `RLSM_ASSERT_IMPL(a_reject_zero, clk_i, rst_ni, done_o && status_o, cell_value_o == '0, "rejected transfer returned a cell value")

endmodule
`default_nettype wire

@@ tb/sv/tb_radial_light_stamp_map.sv @@
// Self-checking testbench for the radial light stamp map: directed and random ops with a mirror.
`timescale 1ns / 1ps
module tb_radial_light_stamp_map;

  localparam int unsigned MAP_DIM_MAX    = 64;
  localparam int unsigned STORE_CELLS    = MAP_DIM_MAX * MAP_DIM_MAX;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_SEG  = 12;

  typedef struct packed {
    logic [rlsm_pkg::VAL_W-1:0] cell_value;
    logic                       status;
  } cell_reply_t;

  // Mirrors the light map and checks each reply against the oldest one due.
  class light_map_checker;
    logic [rlsm_pkg::VAL_W-1:0] light_cells [STORE_CELLS];
    cell_reply_t                replies_due [$];
    int unsigned                cols;
    int unsigned                rows;
    int unsigned                errors;

    function new();
      foreach (light_cells[i]) light_cells[i] = '0;
      cols   = MAP_DIM_MAX;
      rows   = MAP_DIM_MAX;
      errors = 0;
    endfunction

    function void set_size(logic reg_sel, logic [6:0] value);
      int unsigned dim;
      dim = value > MAP_DIM_MAX ? MAP_DIM_MAX : value;
      if (reg_sel == rlsm_pkg::REG_MAP_WIDTH) begin
        cols = dim;
      end else begin
        rows = dim;
      end
    endfunction

    function int unsigned root_floor(int unsigned v);
      int unsigned s;
      s = 0;
      while ((s + 1) * (s + 1) <= v) s++;
      return s;
    endfunction

    function void note_op(rlsm_pkg::op_e op, logic [rlsm_pkg::POS_W-1:0] px,
                          logic [rlsm_pkg::POS_W-1:0] py, logic [rlsm_pkg::RAD_W-1:0] rad,
                          logic [rlsm_pkg::VAL_W-1:0] peak, logic [rlsm_pkg::VAL_W-1:0] ldv);
      int unsigned x, y, r, tx, ty, dx, dy, amt, v, addr;
      cell_reply_t due;
      x   = px;
      y   = py;
      r   = rad;
      due = '0;
      if (op == rlsm_pkg::OP_LOAD || op == rlsm_pkg::OP_READ) begin
        if (x >= cols || y >= rows) begin
          due.status = 1'b1;
        end else if (op == rlsm_pkg::OP_LOAD) begin
          light_cells[x + y * cols] = ldv;
        end else begin
          due.cell_value = light_cells[x + y * cols];
        end
      end else if (x < r || y < r || x + r >= cols || y + r >= rows) begin
        due.status = 1'b1;
      end else if (r != 0) begin
        for (ty = y - r; ty <= y + r; ty++) begin
          for (tx = x - r; tx <= x + r; tx++) begin
            dx = tx > x ? tx - x : x - tx;
            dy = ty > y ? ty - y : y - ty;
            if (dx * dx + dy * dy <= r * r) begin
              addr = tx + ty * cols;
              amt  = (peak * (r - root_floor(dx * dx + dy * dy))) / r;
              v    = light_cells[addr];
              if (op == rlsm_pkg::OP_ADD) begin
                v = v + amt > 255 ? 255 : v + amt;
              end else begin
                v = v > amt ? v - amt : 0;
              end
              light_cells[addr] = v[rlsm_pkg::VAL_W-1:0];
            end
          end
        end
      end
      replies_due.push_back(due);
    endfunction

    function void check_reply(logic [rlsm_pkg::VAL_W-1:0] cell_value, logic status);
      cell_reply_t due;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none due: cell_value %0d status %0d", $time, cell_value,
                 status);
        errors++;
        return;
      end
      due = replies_due.pop_front();
      if (cell_value !== due.cell_value) begin
        $display("%0t: cell_value expected %0d actual %0d", $time, due.cell_value, cell_value);
        errors++;
      end
      if (status !== due.status) begin
        $display("%0t: status expected %0d actual %0d", $time, due.status, status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           start;
  logic                           busy;
  logic [rlsm_pkg::OP_W-1:0]      opcode_i;
  logic [rlsm_pkg::POS_W-1:0]     pos_x_i;
  logic [rlsm_pkg::POS_W-1:0]     pos_y_i;
  logic [rlsm_pkg::RAD_W-1:0]     radius_i;
  logic [rlsm_pkg::VAL_W-1:0]     peak_light_i;
  logic [rlsm_pkg::VAL_W-1:0]     load_value_i;
  logic                           done_o;
  logic [rlsm_pkg::VAL_W-1:0]     cell_value_o;
  logic                           status_o;

  light_map_checker sb;
  bit               loaded [STORE_CELLS];
  int unsigned      map_cols;
  int unsigned      map_rows;
  int unsigned      idle_pct;
  int unsigned      quiet_cycles = 0;
  int unsigned      items_sent = 0;
  int unsigned      seg_end;
  bit               xfer;
  int unsigned      seg_cols [6] = '{64, 20, 3, 127, 64, 37};
  int unsigned      seg_rows [6] = '{64, 12, 64, 5, 1, 29};

  radial_light_stamp_map dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      xfer = 1'b0;
      if (done_o) begin
        sb.check_reply(cell_value_o, status_o);
        xfer = 1'b1;
      end
      if (start && !busy) begin
        sb.note_op(rlsm_pkg::op_e'(opcode_i), pos_x_i, pos_y_i, radius_i, peak_light_i,
                   load_value_i);
        xfer = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        sb.set_size(paddr[2], pwdata[6:0]);
        xfer = 1'b1;
      end
      if (xfer) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL radial_light_stamp_map");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_op(rlsm_pkg::op_e op, int unsigned x, int unsigned y, int unsigned r,
                         int unsigned peak, int unsigned ldv);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    pos_x_i      <= x[rlsm_pkg::POS_W-1:0];
    pos_y_i      <= y[rlsm_pkg::POS_W-1:0];
    radius_i     <= r[rlsm_pkg::RAD_W-1:0];
    peak_light_i <= peak[rlsm_pkg::VAL_W-1:0];
    load_value_i <= ldv[rlsm_pkg::VAL_W-1:0];
    if (op == rlsm_pkg::OP_LOAD && x[rlsm_pkg::POS_W-1:0] < map_cols &&
        y[rlsm_pkg::POS_W-1:0] < map_rows)
      loaded[x[rlsm_pkg::POS_W-1:0] + y[rlsm_pkg::POS_W-1:0] * map_cols] = 1'b1;
    items_sent++;
    do @(posedge clk_i); while (busy);
  endtask

  // Cells under a disc must hold a loaded value before the disc touches them.
  task automatic light_disc(rlsm_pkg::op_e op, int unsigned x, int unsigned y, int unsigned r,
                            int unsigned peak);
    int tx, ty;
    if (r != 0 && x >= r && y >= r && x + r < map_cols && y + r < map_rows) begin
      for (ty = y - r; ty <= y + r; ty++) begin
        for (tx = x - r; tx <= x + r; tx++) begin
          if ((tx - int'(x)) * (tx - int'(x)) + (ty - int'(y)) * (ty - int'(y)) <= r * r &&
              !loaded[tx + ty * map_cols])
            send_op(rlsm_pkg::OP_LOAD, tx, ty, $urandom, $urandom, $urandom);
        end
      end
    end
    send_op(op, x, y, r, peak, $urandom);
  endtask

  task automatic probe_cell(int unsigned x, int unsigned y);
    if (x < map_cols && y < map_rows && !loaded[x + y * map_cols])
      send_op(rlsm_pkg::OP_LOAD, x, y, $urandom, $urandom, $urandom);
    send_op(rlsm_pkg::OP_READ, x, y, $urandom, $urandom, $urandom);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
  endtask

  task automatic set_map_size(int unsigned cols, int unsigned rows);
    int unsigned idx;
    logic [6:0]  value;
    for (idx = 0; idx < 2; idx++) begin
      value   = idx == 0 ? cols[6:0] : rows[6:0];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {((idx == 0) ? rlsm_pkg::REG_MAP_WIDTH : rlsm_pkg::REG_MAP_HEIGHT), 2'b00};
      pwdata  <= {25'd0, value};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    map_cols = cols[6:0] > MAP_DIM_MAX ? MAP_DIM_MAX : cols[6:0];
    map_rows = rows[6:0] > MAP_DIM_MAX ? MAP_DIM_MAX : rows[6:0];
  endtask

  task automatic random_item();
    int unsigned pick, x, y, r, side, rfit, peak;
    pick = $urandom_range(99);
    side = map_cols < map_rows ? map_cols : map_rows;
    if (side != 0 && $urandom_range(99) < 85) begin
      x = $urandom_range(map_cols - 1);
      y = $urandom_range(map_rows - 1);
    end else begin
      x = $urandom_range(63);
      y = $urandom_range(63);
    end
    if (pick < 25) begin
      send_op(rlsm_pkg::OP_LOAD, x, y, $urandom, $urandom, $urandom);
    end else if (pick < 45) begin
      probe_cell(x, y);
    end else begin
      if (side != 0 && $urandom_range(99) < 80) begin
        rfit = (side - 1) / 2;
        r = $urandom_range(99) < 10 ? $urandom_range(rfit < 3 ? rfit : 3) :
                                      $urandom_range(rfit < 2 ? rfit : 2);
        x = $urandom_range(map_cols - 1 - r, r);
        y = $urandom_range(map_rows - 1 - r, r);
      end else begin
        // disc that crosses the left or right edge of the map
        r = $urandom_range(31, 1);
        x = $urandom_range(1) ? $urandom_range(r - 1) :
                                $urandom_range(63, map_cols > r ? map_cols - r : 0);
        y = $urandom_range(63);
      end
      pick = $urandom_range(99);
      peak = pick < 15 ? 255 : pick < 25 ? 0 : $urandom_range(255);
      light_disc($urandom_range(1) ? rlsm_pkg::OP_ADD : rlsm_pkg::OP_REMOVE, x, y, r, peak);
    end
  endtask

  initial begin
    sb = new();
    start        <= 1'b0;
    opcode_i     <= rlsm_pkg::OP_LOAD;
    pos_x_i      <= '0;
    pos_y_i      <= '0;
    radius_i     <= '0;
    peak_light_i <= '0;
    load_value_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    idle_pct     = 35;
    map_cols     = MAP_DIM_MAX;
    map_rows     = MAP_DIM_MAX;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, saturation and clamping, zero radius, rejected and overlapping discs
    send_op(rlsm_pkg::OP_LOAD, 0, 0, 31, 255, 8'h00);
    send_op(rlsm_pkg::OP_LOAD, 63, 63, 0, 0, 8'hff);
    probe_cell(63, 63);
    probe_cell(0, 0);
    send_op(rlsm_pkg::OP_LOAD, 2, 2, 0, 0, 8'hfa);
    light_disc(rlsm_pkg::OP_ADD, 2, 2, 1, 255);
    light_disc(rlsm_pkg::OP_REMOVE, 2, 2, 1, 255);
    probe_cell(2, 2);
    light_disc(rlsm_pkg::OP_ADD, 5, 5, 0, 255);
    light_disc(rlsm_pkg::OP_REMOVE, 0, 0, 0, 0);
    light_disc(rlsm_pkg::OP_ADD, 1, 10, 2, 100);
    light_disc(rlsm_pkg::OP_REMOVE, 61, 10, 3, 100);
    light_disc(rlsm_pkg::OP_ADD, 33, 33, 31, 200);
    light_disc(rlsm_pkg::OP_ADD, 31, 32, 2, 200);
    light_disc(rlsm_pkg::OP_REMOVE, 32, 31, 2, 255);
    light_disc(rlsm_pkg::OP_ADD, 10, 10, 1, 0);
    probe_cell(31, 32);

    settle();
    set_map_size(1, 1);
    send_op(rlsm_pkg::OP_LOAD, 0, 0, 0, 0, 8'h5a);
    send_op(rlsm_pkg::OP_LOAD, 1, 0, 0, 0, 8'ha5);
    probe_cell(0, 1);
    light_disc(rlsm_pkg::OP_ADD, 0, 0, 0, 255);
    light_disc(rlsm_pkg::OP_REMOVE, 0, 0, 1, 255);

    settle();
    set_map_size(0, 1);
    probe_cell(0, 0);
    light_disc(rlsm_pkg::OP_ADD, 0, 0, 0, 10);

    settle();
    set_map_size(127, 100);
    probe_cell(63, 63);
    send_op(rlsm_pkg::OP_LOAD, 63, 0, 0, 0, 8'h3c);

    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = seg < 2 ? 35 : seg < 4 ? 84 : 0;
      settle();
      set_map_size(seg_cols[seg], seg_rows[seg]);
      seg_end = items_sent + ITEMS_PER_SEG;
      while (items_sent < seg_end) random_item();
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS radial_light_stamp_map");
    end else begin
      $display("FAIL radial_light_stamp_map");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/rlsm_pkg.sv
src/rlsm_ctrl.sv
src/rlsm_dp.sv
src/radial_light_stamp_map.sv
tb/sv/tb_radial_light_stamp_map.sv
